@@ rtl/fsmb_pkg.sv @@
package fsmb_pkg;

  // Number of frame slots in the mailbox (2 to 16).
  localparam int SLOTS  = 3;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int IDX_W  = 4;
  localparam int SEQ_W  = 64;
  localparam int DIM_W  = 13;
  localparam int PIT_W  = 16;
  localparam int DROP_W = 4;

  // Slot numbers at or above this limit are out of range.
  localparam logic [IDX_W:0] SLOT_LIMIT = (IDX_W + 1)'(SLOTS);

  // Action codes.
  localparam logic [2:0] ACT_CLAIM   = 3'd0;
  localparam logic [2:0] ACT_COMMIT  = 3'd1;
  localparam logic [2:0] ACT_ACQUIRE = 3'd2;
  localparam logic [2:0] ACT_RELEASE = 3'd3;
  localparam logic [2:0] ACT_STOP    = 3'd4;
  localparam logic [2:0] ACT_RESTART = 3'd5;

  typedef enum logic [1:0] {
    SS_FREE,
    SS_WRITING,
    SS_PUBLISHED,
    SS_READING
  } slot_state_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [IDX_W-1:0] slot_index;
    logic [SEQ_W-1:0] release_sequence;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [PIT_W-1:0] frame_pitch;
    logic             size_ok;
  } in_item_t;

  typedef struct packed {
    logic              done_ok;
    logic [IDX_W-1:0]  granted_slot;
    logic [SEQ_W-1:0]  granted_sequence;
    logic [DIM_W-1:0]  out_width;
    logic [DIM_W-1:0]  out_height;
    logic [PIT_W-1:0]  out_pitch;
    logic [DROP_W-1:0] dropped_count;
  } out_item_t;

  // One entry of the slot memory: sequence stamp and frame metadata.
  typedef struct packed {
    logic [SEQ_W-1:0] stamp;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [PIT_W-1:0] pitch;
  } slot_word_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECIDE,
    CS_RD,
    CS_CMP,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic rd_issue;
    logic cmp;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/fsmb_ctrl.sv @@
module fsmb_ctrl
  import fsmb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_DECIDE;
      end
      CS_DECIDE: begin
        state_nxt = sts.need_scan ? CS_RD : CS_DONE;
      end
      CS_RD: begin
        state_nxt = CS_CMP;
      end
      CS_CMP: begin
        state_nxt = sts.scan_last ? CS_DONE : CS_RD;
      end
      CS_DONE: begin
        if (sts.out_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != CS_IDLE);
    cmd.capture  = (state_r == CS_IDLE) && in_valid;
    cmd.rd_issue = (state_r == CS_RD);
    cmd.cmp      = (state_r == CS_CMP);
    cmd.finish   = (state_r == CS_DONE) && sts.out_free;
  end

endmodule

@@ rtl/fsmb_dp.sv @@
module fsmb_dp
  import fsmb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  in_item_t          item_r;
  slot_state_t       status_r [SLOTS];
  slot_state_t       status_nxt [SLOTS];
  logic              halted_r, halted_nxt;
  logic [SEQ_W-1:0]  next_stamp_r, next_stamp_nxt;

  slot_word_t        slot_mem_r [SLOTS];
  slot_word_t        rd_word_r;
  logic [SLOT_W-1:0] rd_addr;

  logic [SLOT_W-1:0] cnt_r;
  slot_word_t        best_word_r;
  logic [SLOT_W-1:0] best_idx_r;
  logic              best_found_r;
  logic              rel_match_r;

  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         result;

  logic [SLOTS-1:0]  is_free, is_writing, is_pub, is_reading;
  logic [SLOTS-1:0]  sel_idx, sel_cnt, sel_pick;
  logic              any_free;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] pick;
  logic              idx_in_range;
  logic              idx_writing, idx_reading, cnt_pub;
  logic              claim_ok, commit_hit, acquire_ok, release_ok;
  logic              better;
  logic [CNT_W-1:0]  pub_cnt;
  logic              mem_write;

  // Per-slot decode of the status registers, the slot index and the scan counter.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      is_free[i]    = (status_r[i] == SS_FREE);
      is_writing[i] = (status_r[i] == SS_WRITING);
      is_pub[i]     = (status_r[i] == SS_PUBLISHED);
      is_reading[i] = (status_r[i] == SS_READING);
      sel_idx[i]    = (item_r.slot_index == IDX_W'(i));
      sel_cnt[i]    = (cnt_r == SLOT_W'(i));
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (is_free[i]) free_idx = SLOT_W'(i);
    end
  end

  assign any_free     = |is_free;
  assign idx_in_range = ({1'b0, item_r.slot_index} < SLOT_LIMIT);
  assign idx_writing  = |(sel_idx & is_writing);
  assign idx_reading  = |(sel_idx & is_reading);
  assign cnt_pub      = |(sel_cnt & is_pub);
  assign pub_cnt      = CNT_W'($countones(is_pub));

  assign claim_ok   = !halted_r && item_r.size_ok && (any_free || best_found_r);
  assign commit_hit = idx_in_range && idx_writing;
  assign acquire_ok = best_found_r;
  assign release_ok = idx_in_range && idx_reading && rel_match_r;

  assign pick = (item_r.action == ACT_CLAIM && any_free) ? free_idx : best_idx_r;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      sel_pick[i] = (pick == SLOT_W'(i));
    end
  end

  always_comb begin
    sts.scan_last = (item_r.action == ACT_RELEASE) || (cnt_r == SLOT_W'(SLOTS - 1));
    sts.out_free  = !out_valid_r || !out_stall;
    unique case (item_r.action)
      ACT_CLAIM:   sts.need_scan = !halted_r && item_r.size_ok && !any_free;
      ACT_ACQUIRE: sts.need_scan = 1'b1;
      ACT_RELEASE: sts.need_scan = idx_in_range;
      default:     sts.need_scan = 1'b0;
    endcase
  end

  // Scan compare: oldest Published stamp for a claim, newest for an acquire.
  always_comb begin
    if (item_r.action == ACT_CLAIM) begin
      better = cnt_pub && (!best_found_r || (rd_word_r.stamp < best_word_r.stamp));
    end else begin
      better = cnt_pub && (rd_word_r.stamp > best_word_r.stamp);
    end
  end

  assign rd_addr = (item_r.action == ACT_RELEASE) ? item_r.slot_index[SLOT_W-1:0] : cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_word_r <= slot_mem_r[rd_addr];
  end

  assign mem_write = cmd.finish && (item_r.action == ACT_COMMIT) && commit_hit && !halted_r;

  always_ff @(posedge clk) begin
    if (mem_write) begin
      slot_mem_r[item_r.slot_index[SLOT_W-1:0]] <= '{
        stamp:  next_stamp_r,
        width:  item_r.frame_width,
        height: item_r.frame_height,
        pitch:  item_r.frame_pitch
      };
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      best_found_r <= 1'b0;
    end else if (cmd.capture) begin
      cnt_r        <= '0;
      best_found_r <= 1'b0;
    end else if (cmd.cmp) begin
      cnt_r <= cnt_r + SLOT_W'(1);
      if (better) best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      best_word_r.stamp <= '0;
    end else if (cmd.cmp) begin
      rel_match_r <= (rd_word_r.stamp == item_r.release_sequence);
      if (better) begin
        best_word_r <= rd_word_r;
        best_idx_r  <= cnt_r;
      end
    end
  end

  // State update and result of the finished operation.
  always_comb begin
    status_nxt     = status_r;
    halted_nxt     = halted_r;
    next_stamp_nxt = next_stamp_r;
    result         = '0;
    unique case (item_r.action)
      ACT_CLAIM: begin
        if (claim_ok) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (sel_pick[i]) status_nxt[i] = SS_WRITING;
          end
          result.done_ok       = 1'b1;
          result.granted_slot  = IDX_W'(pick);
          result.dropped_count = any_free ? '0 : DROP_W'(1);
        end
      end
      ACT_COMMIT: begin
        if (commit_hit) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (sel_idx[i]) status_nxt[i] = halted_r ? SS_FREE : SS_PUBLISHED;
          end
          if (!halted_r) begin
            next_stamp_nxt = next_stamp_r + SEQ_W'(1);
            result.done_ok = 1'b1;
          end
        end
      end
      ACT_ACQUIRE: begin
        if (acquire_ok) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (sel_pick[i]) begin
              status_nxt[i] = SS_READING;
            end else if (is_pub[i]) begin
              status_nxt[i] = SS_FREE;
            end
          end
          result.done_ok          = 1'b1;
          result.granted_slot     = IDX_W'(pick);
          result.granted_sequence = best_word_r.stamp;
          result.out_width        = best_word_r.width;
          result.out_height       = best_word_r.height;
          result.out_pitch        = best_word_r.pitch;
          result.dropped_count    = DROP_W'(pub_cnt - CNT_W'(1));
        end
      end
      ACT_RELEASE: begin
        if (release_ok) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (sel_idx[i]) status_nxt[i] = SS_FREE;
          end
          result.done_ok = 1'b1;
        end
      end
      ACT_STOP: begin
        halted_nxt     = 1'b1;
        result.done_ok = 1'b1;
      end
      ACT_RESTART: begin
        for (int i = 0; i < SLOTS; i++) begin
          status_nxt[i] = SS_FREE;
        end
        halted_nxt     = 1'b0;
        next_stamp_nxt = SEQ_W'(1);
        result.done_ok = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        status_r[i] <= SS_FREE;
      end
      halted_r     <= 1'b0;
      next_stamp_r <= SEQ_W'(1);
    end else if (cmd.finish) begin
      status_r     <= status_nxt;
      halted_r     <= halted_nxt;
      next_stamp_r <= next_stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/frame_slot_mailbox_unit.sv @@
// Control side of a frame mailbox with SLOTS frame slots.
// An operation (claim, commit, acquire, release, stop or restart) enters on the
// in_ channel and is transferred when in_valid is high and in_stall is low.
// Every operation gives exactly one result, transferred on the out_ channel
// when out_valid is high and out_stall is low.
// A commit, stop, restart, and a claim that finds a Free slot or fails its
// checks go straight from the decision to the result; a release with an
// in-range slot number takes one read and compare step; an acquire, or a
// claim that must overwrite the oldest Published slot, scans the slot memory
// one slot per read and compare step.
// One operation is worked on at a time; the next is taken in the idle state
// that follows the loading of the result into the output register.
// A waiting result does not hold up the next operation until that one is
// finished; it then waits in the controller while out_stall stays high.
// After reset all slots are Free, the stop flag is clear and the next
// sequence number is one; a restart operation has the same effect.
module frame_slot_mailbox_unit
  import fsmb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Commands from the controller and status back from the datapath.
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // The controller sequences capture, optional memory scan and finish.
  fsmb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds slot status, slot memory, counters and the output register.
  fsmb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ test/mailbox_checker.sv @@
`timescale 1ns / 1ps

module mailbox_checker
  import fsmb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  slot_state_t      slot_state [SLOTS];
  logic [SEQ_W-1:0] slot_seq   [SLOTS];
  logic [DIM_W-1:0] slot_wid   [SLOTS];
  logic [DIM_W-1:0] slot_hgt   [SLOTS];
  logic [PIT_W-1:0] slot_pit   [SLOTS];
  logic [SEQ_W-1:0] seq_next;
  logic             stopped;
  out_item_t        expected_results [$];
  int               fails = 0;

  assign fail_count = fails;

  function automatic void clear_mailbox();
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i] = SS_FREE;
      slot_seq[i]   = '0;
      slot_wid[i]   = '0;
      slot_hgt[i]   = '0;
      slot_pit[i]   = '0;
    end
    seq_next = SEQ_W'(1);
    stopped  = 1'b0;
  endfunction

  // Applies one operation to the mailbox copy and returns the result it gives.
  function automatic out_item_t mailbox_op(input in_item_t op);
    out_item_t        res;
    int               pick;
    int               idx;
    int               freed;
    bit               found;
    logic [SEQ_W-1:0] newest;
    res    = '0;
    pick   = 0;
    freed  = 0;
    found  = 1'b0;
    newest = '0;
    idx    = int'(op.slot_index);
    case (op.action)
      ACT_CLAIM: begin
        if (!stopped && op.size_ok) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_state[i] == SS_FREE) begin
              pick  = i;
              found = 1'b1;
            end
          end
          // With no Free slot the oldest Published frame is overwritten.
          if (!found) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_state[i] == SS_PUBLISHED &&
                  (!found || slot_seq[i] < slot_seq[pick])) begin
                pick  = i;
                found = 1'b1;
              end
            end
            freed = found ? 1 : 0;
          end
          if (found) begin
            slot_state[pick]  = SS_WRITING;
            res.done_ok       = 1'b1;
            res.granted_slot  = IDX_W'(pick);
            res.dropped_count = DROP_W'(freed);
          end
        end
      end
      ACT_COMMIT: begin
        if (idx < SLOTS) begin
          if (slot_state[idx] == SS_WRITING) begin
            if (stopped) begin
              slot_state[idx] = SS_FREE;
            end else begin
              slot_wid[idx]   = op.frame_width;
              slot_hgt[idx]   = op.frame_height;
              slot_pit[idx]   = op.frame_pitch;
              slot_seq[idx]   = seq_next;
              seq_next        = seq_next + SEQ_W'(1);
              slot_state[idx] = SS_PUBLISHED;
              res.done_ok     = 1'b1;
            end
          end
        end
      end
      ACT_ACQUIRE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_state[i] == SS_PUBLISHED && slot_seq[i] > newest) begin
            pick   = i;
            newest = slot_seq[i];
            found  = 1'b1;
          end
        end
        if (found) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (i != pick && slot_state[i] == SS_PUBLISHED) begin
              slot_state[i] = SS_FREE;
              freed++;
            end
          end
          slot_state[pick]     = SS_READING;
          res.done_ok          = 1'b1;
          res.granted_slot     = IDX_W'(pick);
          res.granted_sequence = slot_seq[pick];
          res.out_width        = slot_wid[pick];
          res.out_height       = slot_hgt[pick];
          res.out_pitch        = slot_pit[pick];
          res.dropped_count    = DROP_W'(freed);
        end
      end
      ACT_RELEASE: begin
        if (idx < SLOTS) begin
          if (slot_state[idx] == SS_READING && slot_seq[idx] == op.release_sequence) begin
            slot_state[idx] = SS_FREE;
            res.done_ok     = 1'b1;
          end
        end
      end
      ACT_STOP: begin
        stopped     = 1'b1;
        res.done_ok = 1'b1;
      end
      ACT_RESTART: begin
        clear_mailbox();
        res.done_ok = 1'b1;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [SEQ_W-1:0] want,
                               input logic [SEQ_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result %0h with nothing expected", $time, got);
      fails++;
    end else begin
      want = expected_results.pop_front();
      compare_field("done_ok", SEQ_W'(want.done_ok), SEQ_W'(got.done_ok));
      compare_field("granted_slot", SEQ_W'(want.granted_slot), SEQ_W'(got.granted_slot));
      compare_field("granted_sequence", want.granted_sequence, got.granted_sequence);
      compare_field("out_width", SEQ_W'(want.out_width), SEQ_W'(got.out_width));
      compare_field("out_height", SEQ_W'(want.out_height), SEQ_W'(got.out_height));
      compare_field("out_pitch", SEQ_W'(want.out_pitch), SEQ_W'(got.out_pitch));
      compare_field("dropped_count", SEQ_W'(want.dropped_count),
                    SEQ_W'(got.dropped_count));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_mailbox();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) expected_results.push_back(mailbox_op(in_data));
    end
    pending <= expected_results.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the frame slot mailbox. The top level only produces operations,
// drives the receiver stall and gives the verdict; the checker beside the block
// predicts every result and compares it, field by field, with what the block hands back.
module tb_top;
  import fsmb_pkg::*;

  // The run is ended here whatever happens; it is many times the slowest
  // correct run, long hold-off included.
  localparam int CYCLE_LIMIT      = 400_000;
  localparam int RANDOM_PER_PHASE = 370;
  localparam int HOLD_CYCLES      = 400;
  localparam int POOL_DEPTH       = 6;

  // The two action codes that the block does not use.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  // A frame handed to a reader: the slot and the sequence number to release.
  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic [SEQ_W-1:0] seq;
  } held_frame_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int cycle_count     = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;

  // Long hold-off of the receiver: requested by the stimulus, timed by the
  // receiver process itself.
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  // Actions in flight, in order, and what the results told us about slots.
  // The pools only steer the stimulus towards well-formed sequences.
  logic [2:0]       issued_actions [$];
  logic [IDX_W-1:0] writing_slots  [$];
  held_frame_t      reading_frames [$];

  frame_slot_mailbox_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mailbox_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver. Once asked, it refuses every transfer for a long stretch so that
  // the block fills up; otherwise it stalls at random at the current rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Watches both channels at the falling edge, where valid and stall already
  // show whether a transfer will take place at the next rising edge. Doing it
  // here keeps the pools settled before the stimulus reads them.
  always @(negedge clk) begin
    logic [2:0] act;
    if (rst_n) begin
      if (out_valid && !out_stall && issued_actions.size() != 0) begin
        act = issued_actions.pop_front();
        if (out_data.done_ok && act == ACT_CLAIM) begin
          if (writing_slots.size() >= POOL_DEPTH) void'(writing_slots.pop_front());
          writing_slots.push_back(out_data.granted_slot);
        end
        if (out_data.done_ok && act == ACT_ACQUIRE) begin
          if (reading_frames.size() >= POOL_DEPTH) void'(reading_frames.pop_front());
          reading_frames.push_back({out_data.granted_slot, out_data.granted_sequence});
        end
      end
      if (in_valid && !in_stall) issued_actions.push_back(in_data.action);
    end
  end

  function automatic in_item_t make_op(input logic [2:0] act, input logic [IDX_W-1:0] slot,
                                       input logic [SEQ_W-1:0] seq,
                                       input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                       input logic [PIT_W-1:0] p, input logic ok);
    in_item_t op;
    op.action           = act;
    op.slot_index       = slot;
    op.release_sequence = seq;
    op.frame_width      = w;
    op.frame_height     = h;
    op.frame_pitch      = p;
    op.size_ok          = ok;
    return op;
  endfunction

  // Random operation. Every field starts as random bits; the action is then
  // weighted towards claim, commit, acquire and release, and most commits and
  // releases name a slot that a result has just told us about, so that frames
  // go all the way round. The rest is noise: bad slot numbers, wrong sequence
  // numbers, failed geometry checks, stops, restarts and the unused codes.
  function automatic in_item_t pick_next_op();
    in_item_t     op;
    logic [127:0] raw;
    held_frame_t  held;
    int           roll;
    raw  = {$urandom(), $urandom(), $urandom(), $urandom()};
    op   = raw[$bits(in_item_t)-1:0];
    roll = $urandom_range(999);
    if (roll < 260) begin
      op.action  = ACT_CLAIM;
      op.size_ok = ($urandom_range(9) != 0);
    end else if (roll < 500) begin
      op.action = ACT_COMMIT;
      if (writing_slots.size() != 0 && $urandom_range(9) != 0)
        op.slot_index = writing_slots.pop_front();
    end else if (roll < 700) begin
      op.action = ACT_ACQUIRE;
    end else if (roll < 920) begin
      op.action = ACT_RELEASE;
      if (reading_frames.size() != 0 && $urandom_range(6) != 0) begin
        held                = reading_frames.pop_front();
        op.slot_index       = held.slot;
        op.release_sequence = held.seq;
      end else if ($urandom_range(1) != 0) begin
        // Small numbers now and then match a real sequence number by chance.
        op.release_sequence = SEQ_W'($urandom_range(8));
      end
    end else if (roll < 935) begin
      op.action = ACT_STOP;
    end else if (roll < 985) begin
      // Everything learnt about the slots is void after a restart.
      op.action = ACT_RESTART;
      writing_slots.delete();
      reading_frames.delete();
    end else begin
      op.action = ($urandom_range(1) != 0) ? ACT_SPARE_A : ACT_SPARE_B;
    end
    return op;
  endfunction

  // Offers one operation and holds it, unchanged, until the transfer. Valid
  // stays high afterwards unless an idle gap is drawn, so the sender itself
  // leaves no gap between operations.
  task automatic send_one(input in_item_t op);
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // The sender stops offering and waits until every result has been taken.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (issued_actions.size() != 0) @(posedge clk);
  endtask

  // Directed opening: empty mailbox, failed geometry check, every slot being
  // written, overwrite of the oldest published frame, extreme metadata, bad
  // and out-of-range slot numbers, a matching and a mismatching release, the
  // unused action codes, and the behaviour while stopped.
  task automatic run_directed();
    held_frame_t held;
    held = '0;
    send_one(make_op(ACT_ACQUIRE, 4'd0, '0, '0, '0, '0, 1'b1));
    send_one(make_op(ACT_CLAIM, 4'd0, '0, '0, '0, '0, 1'b0));
    repeat (3) send_one(make_op(ACT_CLAIM, 4'd0, '0, '0, '0, '0, 1'b1));
    // All slots are being written, so this claim has nowhere to go.
    send_one(make_op(ACT_CLAIM, 4'd0, '0, '0, '0, '0, 1'b1));
    send_one(make_op(ACT_COMMIT, 4'd0, '0, '1, '1, '1, 1'b0));
    send_one(make_op(ACT_COMMIT, 4'd1, '0, '0, '0, '0, 1'b0));
    send_one(make_op(ACT_COMMIT, 4'd2, '0, 13'd1920, 13'd1080, 16'd7680, 1'b0));
    // No Free slot: the oldest published frame is overwritten and counted.
    send_one(make_op(ACT_CLAIM, 4'd0, '0, '0, '0, '0, 1'b1));
    send_one(make_op(ACT_COMMIT, 4'd0, '0, 13'd640, 13'd480, 16'd1280, 1'b1));
    send_one(make_op(ACT_COMMIT, 4'(SLOTS), '0, '1, '1, '1, 1'b1));
    send_one(make_op(ACT_COMMIT, 4'd15, '0, '1, '1, '1, 1'b1));
    send_one(make_op(ACT_COMMIT, 4'd1, '0, '1, '1, '1, 1'b1));
    // Newest frame goes to the reader, the other published ones are freed.
    send_one(make_op(ACT_ACQUIRE, 4'd0, '0, '0, '0, '0, 1'b1));
    pause_until_drained();
    if (reading_frames.size() != 0) held = reading_frames.pop_back();
    send_one(make_op(ACT_RELEASE, held.slot, held.seq ^ SEQ_W'(1), '0, '0, '0, 1'b0));
    send_one(make_op(ACT_RELEASE, held.slot, held.seq, '0, '0, '0, 1'b0));
    send_one(make_op(ACT_RELEASE, 4'd15, '1, '0, '0, '0, 1'b0));
    send_one(make_op(ACT_SPARE_A, '1, '1, '1, '1, '1, 1'b1));
    send_one(make_op(ACT_SPARE_B, '1, '1, '1, '1, '1, 1'b1));
    // Publish one frame, start writing another, then stop: the commit frees
    // its slot, the claim fails, but acquire still works.
    send_one(make_op(ACT_CLAIM, 4'd0, '0, '0, '0, '0, 1'b1));
    send_one(make_op(ACT_COMMIT, 4'd0, '0, 13'd3, 13'd5, 16'd7, 1'b1));
    send_one(make_op(ACT_CLAIM, 4'd0, '0, '0, '0, '0, 1'b1));
    send_one(make_op(ACT_STOP, 4'd0, '0, '0, '0, '0, 1'b1));
    send_one(make_op(ACT_COMMIT, 4'd1, '0, 13'd9, 13'd9, 16'd9, 1'b1));
    send_one(make_op(ACT_CLAIM, 4'd0, '0, '0, '0, '0, 1'b1));
    send_one(make_op(ACT_ACQUIRE, 4'd0, '0, '0, '0, '0, 1'b1));
    send_one(make_op(ACT_RESTART, 4'd0, '0, '0, '0, '0, 1'b1));
    pause_until_drained();
    writing_slots.delete();
    reading_frames.delete();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Four random phases: no idling, an idle sender, a stalling receiver, and
    // both at once. Each ends with the sender waiting for every result.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          stall_pct      <= 0;
        end
        1: begin
          sender_idle_pct = 63;
          stall_pct      <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct      <= 63;
        end
        default: begin
          sender_idle_pct = 28;
          stall_pct      <= 28;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_one(pick_next_op());
      pause_until_drained();
    end

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the block fills and refuses further transfers.
    sender_idle_pct = 0;
    stall_pct      <= 0;
    hold_go        <= 1'b1;
    repeat (40) send_one(pick_next_op());
    pause_until_drained();

    // The bench waits on in case the block sends anything unasked for.
    repeat (20) @(posedge clk);
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
